// ===== rtl/core/las_pkg.sv =====
// Shared types and constants for the line assembler with line queue.
package las_pkg;

    // Result kinds
    localparam int KIND_W = 2;
    localparam logic [KIND_W-1:0] KIND_BYTE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_BAD  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_NONE = 2'd2;

    // Width of the lines_left field
    localparam int LEFT_W = 4;

    // Input command codes
    localparam logic CMD_BYTE = 1'b0;
    localparam logic CMD_POP  = 1'b1;

    // Special characters
    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_BS  = 8'h08;
    localparam logic [7:0] CH_DEL = 8'h7F;

    typedef enum logic {
        ST_IDLE,
        ST_POP
    } state_t;

endpackage

// ===== rtl/core/line_assembler_with_line_queue.sv =====
// Line assembler: gathers received bytes into lines and queues complete lines.
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  in      | in_valid, in_stall, command, byte_value   | into block
//  out     | out_valid, out_stall, kind, line_byte,    | out of block
//          | last, lines_left                          |
//
// A received byte gives no item; bytes may arrive back to back while the input is not stalled.
// A pop that reports a bad line or an empty queue gives a single status item. A pop of a
// queued line of N bytes streams N items, one per cycle while the output is not stalled,
// after a registered read of the line memory, whose single read port sets the pace.
// Reset clears state, flags, pointers and count; pop indices and memories are not cleared.
// While the output is stalled, hold the result and stall the input.
module line_assembler_with_line_queue #(
    parameter int LINE_BYTES  = 64,
    parameter int QUEUE_DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic                     command,
    input  logic [7:0]               byte_value,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic [las_pkg::KIND_W-1:0] kind,
    output logic [7:0]               line_byte,
    output logic                     last,
    output logic [las_pkg::LEFT_W-1:0] lines_left
);
    import las_pkg::*;

    // The active line is built directly inside a free region of the line
    // memory. With one region more than there are queue slots, the region
    // under construction never overlaps a queued line, so committing a line
    // is just a pointer bump, a count increment and a length write.
    localparam int OW      = $clog2(LINE_BYTES);       // offset within a region
    localparam int REGIONS = QUEUE_DEPTH + 1;
    localparam int RW      = $clog2(REGIONS);          // region index
    localparam int CW      = $clog2(QUEUE_DEPTH + 1);  // queued line count
    localparam int AW      = RW + OW;
    localparam int DEPTH   = REGIONS * (1 << OW);

    function automatic logic [RW-1:0] next_region(input logic [RW-1:0] r);
        next_region = (r == RW'(QUEUE_DEPTH)) ? '0 : RW'(r + RW'(1));
    endfunction

    // Memories
    logic [7:0]    data_mem [DEPTH];
    logic [OW-1:0] len_mem  [REGIONS];
    logic [7:0]    data_rd_reg;
    logic [OW-1:0] len_rd_reg;

    logic          dm_we, dm_re, lm_we, lm_re;
    logic [AW-1:0] dm_waddr, dm_raddr;
    logic [7:0]    dm_wdata;

    // Control state
    state_t        state_reg, state_next;
    logic [OW-1:0] act_len_reg, act_len_next;
    logic          ovf_reg, ovf_next;
    logic          bad_reg, bad_next;
    logic [RW-1:0] wr_reg, wr_next;
    logic [RW-1:0] rd_reg, rd_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [RW-1:0] pop_reg, pop_next;
    logic [OW-1:0] rd_idx_reg, rd_idx_next;
    logic          pend_reg, pend_next;
    logic [OW-1:0] pend_idx_reg, pend_idx_next;

    // Output register
    logic              out_valid_reg, out_valid_next;
    logic [KIND_W-1:0] kind_reg, kind_next;
    logic [7:0]        byte_reg, byte_next;
    logic              last_reg, last_next;
    logic [LEFT_W-1:0] left_reg, left_next;

    logic accept, out_free, move, is_last;

    assign in_stall = (state_reg != ST_IDLE) || (out_valid_reg && out_stall);
    assign accept   = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;
    assign move     = pend_reg && out_free;
    assign is_last  = (pend_idx_reg == OW'(len_rd_reg - OW'(1)));

    assign out_valid  = out_valid_reg;
    assign kind       = kind_reg;
    assign line_byte  = byte_reg;
    assign last       = last_reg;
    assign lines_left = left_reg;

    // Next state and memory controls
    always_comb
    begin
        state_next     = state_reg;
        act_len_next   = act_len_reg;
        ovf_next       = ovf_reg;
        bad_next       = bad_reg;
        wr_next        = wr_reg;
        rd_next        = rd_reg;
        cnt_next       = cnt_reg;
        pop_next       = pop_reg;
        rd_idx_next    = rd_idx_reg;
        pend_next      = pend_reg;
        pend_idx_next  = pend_idx_reg;
        out_valid_next = out_valid_reg && out_stall;
        kind_next      = kind_reg;
        byte_next      = byte_reg;
        last_next      = last_reg;
        left_next      = left_reg;
        dm_we          = 1'b0;
        dm_waddr       = {wr_reg, act_len_reg};
        dm_wdata       = byte_value;
        dm_re          = 1'b0;
        dm_raddr       = {rd_reg, OW'(0)};
        lm_we          = 1'b0;
        lm_re          = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept && command == CMD_BYTE)
                begin
                    if (byte_value == CH_CR || byte_value == CH_LF)
                    begin
                        // Terminator: close the line; report an overlong one or a full queue as bad
                        if (ovf_reg)
                        begin
                            bad_next = 1'b1;
                            ovf_next = 1'b0;
                        end
                        else if (act_len_reg != '0)
                        begin
                            if (cnt_reg < CW'(QUEUE_DEPTH))
                            begin
                                lm_we    = 1'b1;
                                wr_next  = next_region(wr_reg);
                                cnt_next = CW'(cnt_reg + CW'(1));
                            end
                            else
                            begin
                                bad_next = 1'b1;
                            end
                        end
                        act_len_next = '0;
                    end
                    else if (byte_value == CH_BS || byte_value == CH_DEL)
                    begin
                        if (!ovf_reg && act_len_reg != '0)
                        begin
                            act_len_next = OW'(act_len_reg - OW'(1));
                        end
                    end
                    else if (!ovf_reg)
                    begin
                        if (act_len_reg < OW'(LINE_BYTES - 1))
                        begin
                            dm_we        = 1'b1;
                            act_len_next = OW'(act_len_reg + OW'(1));
                        end
                        else
                        begin
                            ovf_next     = 1'b1;
                            act_len_next = '0;
                        end
                    end
                end
                else if (accept)
                begin
                    if (bad_reg)
                    begin
                        bad_next       = 1'b0;
                        out_valid_next = 1'b1;
                        kind_next      = KIND_BAD;
                        byte_next      = '0;
                        last_next      = 1'b1;
                        left_next      = LEFT_W'(cnt_reg);
                    end
                    else if (cnt_reg == '0)
                    begin
                        out_valid_next = 1'b1;
                        kind_next      = KIND_NONE;
                        byte_next      = '0;
                        last_next      = 1'b1;
                        left_next      = '0;
                    end
                    else
                    begin
                        // Start a line pop: fetch its length and first byte
                        lm_re         = 1'b1;
                        dm_re         = 1'b1;
                        pop_next      = rd_reg;
                        rd_next       = next_region(rd_reg);
                        cnt_next      = CW'(cnt_reg - CW'(1));
                        rd_idx_next   = OW'(1);
                        pend_next     = 1'b1;
                        pend_idx_next = '0;
                        state_next    = ST_POP;
                    end
                end
            end

            ST_POP:
            begin
                if (move)
                begin
                    out_valid_next = 1'b1;
                    kind_next      = KIND_BYTE;
                    byte_next      = data_rd_reg;
                    last_next      = is_last;
                    left_next      = LEFT_W'(cnt_reg);
                    pend_next      = 1'b0;
                    if (is_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
                // Fetch the next byte once the read register is free
                if ((!pend_reg || move) && rd_idx_reg < len_rd_reg)
                begin
                    dm_re         = 1'b1;
                    dm_raddr      = {pop_reg, rd_idx_reg};
                    pend_next     = 1'b1;
                    pend_idx_next = rd_idx_reg;
                    rd_idx_next   = OW'(rd_idx_reg + OW'(1));
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_len_reg   <= '0;
            ovf_reg       <= 1'b0;
            bad_reg       <= 1'b0;
            wr_reg        <= '0;
            rd_reg        <= '0;
            cnt_reg       <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            act_len_reg   <= act_len_next;
            ovf_reg       <= ovf_next;
            bad_reg       <= bad_next;
            wr_reg        <= wr_next;
            rd_reg        <= rd_next;
            cnt_reg       <= cnt_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        pop_reg      <= pop_next;
        rd_idx_reg   <= rd_idx_next;
        pend_idx_reg <= pend_idx_next;
        kind_reg     <= kind_next;
        byte_reg     <= byte_next;
        last_reg     <= last_next;
        left_reg     <= left_next;
    end

    // Line memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (dm_we)
        begin
            data_mem[dm_waddr] <= dm_wdata;
        end
        if (dm_re)
        begin
            data_rd_reg <= data_mem[dm_raddr];
        end
    end

    // Length memory: written on commit, read at the start of a pop
    always_ff @(posedge clk)
    begin
        if (lm_we)
        begin
            len_mem[wr_reg] <= act_len_reg;
        end
        if (lm_re)
        begin
            len_rd_reg <= len_mem[rd_reg];
        end
    end

endmodule

// ===== rtl/core/las_checker.sv =====
// Port-level checker for the line assembler, bound to the top level.
module las_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       out_valid,
    input logic                       out_stall,
    input logic [las_pkg::KIND_W-1:0] kind,
    input logic [7:0]                 line_byte,
    input logic                       last,
    input logic [las_pkg::LEFT_W-1:0] lines_left
);
    import las_pkg::*;

    // Hold a stalled item
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(kind) && $stable(line_byte)
            && $stable(last) && $stable(lines_left))
        else $error("stalled output item changed");

    // Status reports are single items with no data
    a_report_form: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind != KIND_BYTE |-> last && line_byte == 8'd0)
        else $error("status report malformed");

    // Nothing queued means no lines left
    a_none_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_NONE |-> lines_left == '0)
        else $error("empty report with lines left");

    // Stream a line without gaps once an item is taken
    a_stream: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && kind == KIND_BYTE && !last
            |=> out_valid && kind == KIND_BYTE && $stable(lines_left))
        else $error("line stream broken");

endmodule

bind line_assembler_with_line_queue las_checker u_las_checker (.*);
